// ===== rtl/gtl_pkg.sv =====
// ----------------------------------------------------------------------------
// gtl_pkg
// shared widths, reset values, register indexes and saturation helpers
// ----------------------------------------------------------------------------
package gtl_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MUL_A_W   = 48;
  localparam int unsigned MUL_B_W   = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENG_RATE  = 2'd3;

  localparam logic [30:0] STIFFNESS_RESET = 31'd419430400;
  localparam logic [30:0] DAMPING_RESET   = 31'd7340032;
  localparam logic [31:0] TIME_STEP_RESET = 32'd10737418;
  localparam logic [30:0] ENG_RATE_RESET  = 31'd59578;
  localparam logic signed [31:0] THRUST_RESET = 32'sd19660800;

  localparam logic signed [48:0] ACC_LIMIT     = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] ACC_LIMIT_NEG = -49'sh0_7FFF_FFFF_FFFF;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    if (x > 50'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -50'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return x[31:0];
    end
  endfunction

  function automatic logic signed [47:0] clamp_acc(input logic signed [48:0] x);
    if (x > ACC_LIMIT) begin
      return ACC_LIMIT[47:0];
    end else if (x < ACC_LIMIT_NEG) begin
      return ACC_LIMIT_NEG[47:0];
    end else begin
      return x[47:0];
    end
  endfunction

endpackage

// ===== rtl/gtl_in_if.sv =====
// ----------------------------------------------------------------------------
// gtl_in_if
// command channel: two gimbal angle commands and a thrust command per beat
// ----------------------------------------------------------------------------
interface gtl_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cmd_angle_first;
  logic signed [31:0] cmd_angle_second;
  logic signed [31:0] cmd_thrust;

  modport source (
    output valid, cmd_angle_first, cmd_angle_second, cmd_thrust,
    input  ready
  );
  modport sink (
    input  valid, cmd_angle_first, cmd_angle_second, cmd_thrust,
    output ready
  );
endinterface

// ===== rtl/gtl_out_if.sv =====
// ----------------------------------------------------------------------------
// gtl_out_if
// result channel: modeled gimbal angles and thrust per beat
// ----------------------------------------------------------------------------
interface gtl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_first;
  logic signed [31:0] angle_second;
  logic signed [31:0] thrust_out;

  modport source (
    output valid, angle_first, angle_second, thrust_out,
    input  ready
  );
  modport sink (
    input  valid, angle_first, angle_second, thrust_out,
    output ready
  );
endinterface

// ===== rtl/gtl_serial_mul.sv =====
// ----------------------------------------------------------------------------
// gtl_serial_mul
// bit-serial signed by unsigned shift-add multiplier, one multiplier bit
// per cycle; product is {prod_hi_o, prod_lo_o}
// ----------------------------------------------------------------------------
module gtl_serial_mul #(
  parameter int unsigned WA = gtl_pkg::MUL_A_W,
  parameter int unsigned WB = gtl_pkg::MUL_B_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [WA-1:0] a_i,
  input  logic        [WB-1:0] b_i,
  output logic                 busy_o,
  output logic signed [WA:0]   prod_hi_o,
  output logic        [WB-1:0] prod_lo_o
);

  localparam int unsigned CNT_W = $clog2(WB + 1);

  logic [CNT_W-1:0]   cnt_q;
  logic signed [WA-1:0] a_q;
  logic signed [WA:0] hi_q;
  logic [WB-1:0]      b_q;
  logic signed [WA:0] sum;

  assign sum = hi_q + (b_q[0] ? {a_q[WA-1], a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(WB);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      hi_q <= '0;
    end else if (cnt_q != '0) begin
      hi_q <= sum >>> 1;
      b_q  <= {sum[0], b_q[WB-1:1]};
    end
  end

  assign busy_o    = (cnt_q != '0);
  assign prod_hi_o = hi_q;
  assign prod_lo_o = b_q;

endmodule

// ===== rtl/gimbal_and_thrust_lag_model_core.sv =====
// ----------------------------------------------------------------------------
// gimbal_and_thrust_lag_model_core
// two spring-damper gimbal axes and a first-order thrust lag, Euler stepped
//
// in_i carries one command beat (two angles, one thrust, signed Q16.16);
// out_o returns one beat with the new angles and thrust, saturated.
// ten products per beat run one after another through a single bit-serial
// multiplier, each as a load, a pass over the multiplier bits and a write
// back; a new command is taken only once the previous one is through.
// in_i.ready is high only while no beat is in work.
// the result sits in an output register: a stalled receiver does not stop
// the next command, only the hand-off of the following result.
// cfg_we_i writes gains and the time step; write only while idle.
// reset loads the default gains, zero angles and velocities, thrust 300.0.
// ----------------------------------------------------------------------------
module gimbal_and_thrust_lag_model_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gtl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gtl_pkg::DATA_W-1:0]    cfg_data_i,
  gtl_in_if.sink                        in_i,
  gtl_out_if.source                     out_o
);
  import gtl_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [1:0] SUB_SPRING = 2'd0;
  localparam logic [1:0] SUB_DAMP   = 2'd1;
  localparam logic [1:0] SUB_DPOS   = 2'd2;
  localparam logic [1:0] SUB_DVEL   = 2'd3;
  localparam logic       TH_RATE    = 1'b0;
  localparam logic       TH_INC     = 1'b1;
  localparam logic [3:0] OP_LAST    = 4'd9;

  logic [1:0] state_q;
  logic [3:0] op_q;

  logic [30:0] kp_q, kd_q, rate_q;
  logic [31:0] dt_q;

  logic signed [31:0] cmd_ang_q [2];
  logic signed [31:0] cmd_thr_q;
  logic signed [31:0] pos_q [2];
  logic signed [31:0] vel_q [2];
  logic signed [31:0] thr_q;
  logic signed [47:0] spring_q;
  logic signed [47:0] acc_q;

  logic               out_valid_q;
  logic signed [31:0] out_ang0_q, out_ang1_q, out_thr_q;

  logic                         mul_start, mul_busy;
  logic signed [MUL_A_W-1:0]    mul_a;
  logic        [MUL_B_W-1:0]    mul_b;
  logic signed [MUL_A_W:0]      prod_hi;
  logic        [MUL_B_W-1:0]    prod_lo;

  logic               ax;
  logic [1:0]         sub;
  logic signed [32:0] err;
  logic signed [47:0] f16;
  logic signed [48:0] acc_diff;
  logic signed [49:0] pos_sum, vel_sum, thr_sum;
  logic               wb;

  assign ax  = op_q[2];
  assign sub = op_q[1:0];

  always_comb begin
    err   = '0;
    mul_a = '0;
    mul_b = '0;
    if (op_q[3]) begin
      err = {cmd_thr_q[31], cmd_thr_q} - {thr_q[31], thr_q};
      unique case (op_q[0])
        TH_RATE: begin
          mul_a = {{(MUL_A_W-33){err[32]}}, err};
          mul_b = {1'b0, rate_q};
        end
        TH_INC: begin
          mul_a = acc_q;
          mul_b = dt_q;
        end
        default: ;
      endcase
    end else begin
      err = {cmd_ang_q[ax][31], cmd_ang_q[ax]} - {pos_q[ax][31], pos_q[ax]};
      unique case (sub)
        SUB_SPRING: begin
          mul_a = {{(MUL_A_W-33){err[32]}}, err};
          mul_b = {1'b0, kp_q};
        end
        SUB_DAMP: begin
          mul_a = {{(MUL_A_W-32){vel_q[ax][31]}}, vel_q[ax]};
          mul_b = {1'b0, kd_q};
        end
        SUB_DPOS: begin
          mul_a = {{(MUL_A_W-32){vel_q[ax][31]}}, vel_q[ax]};
          mul_b = dt_q;
        end
        SUB_DVEL: begin
          mul_a = acc_q;
          mul_b = dt_q;
        end
        default: ;
      endcase
    end
  end

  assign mul_start = (state_q == ST_LOAD);
  assign wb        = (state_q == ST_RUN) && !mul_busy;

  // product floored by 2^16 and by 2^32
  assign f16      = {prod_hi[31:0], prod_lo[MUL_B_W-1:16]};
  assign acc_diff = {spring_q[47], spring_q} - {f16[47], f16};
  assign pos_sum  = {{18{pos_q[ax][31]}}, pos_q[ax]} + {prod_hi[MUL_A_W], prod_hi};
  assign vel_sum  = {{18{vel_q[ax][31]}}, vel_q[ax]} + {prod_hi[MUL_A_W], prod_hi};
  assign thr_sum  = {{18{thr_q[31]}}, thr_q} + {prod_hi[MUL_A_W], prod_hi};

  gtl_serial_mul #(
    .WA(MUL_A_W),
    .WB(MUL_B_W)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .busy_o   (mul_busy),
    .prod_hi_o(prod_hi),
    .prod_lo_o(prod_lo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= STIFFNESS_RESET;
      kd_q   <= DAMPING_RESET;
      dt_q   <= TIME_STEP_RESET;
      rate_q <= ENG_RATE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STIFFNESS: kp_q   <= cfg_data_i[30:0];
        CFG_DAMPING:   kd_q   <= cfg_data_i[30:0];
        CFG_TIME_STEP: dt_q   <= cfg_data_i;
        CFG_ENG_RATE:  rate_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= '0;
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      vel_q[0] <= '0;
      vel_q[1] <= '0;
      thr_q    <= THRUST_RESET;
      spring_q <= '0;
      acc_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            op_q    <= '0;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (wb) begin
            if (op_q[3]) begin
              if (op_q[0] == TH_RATE) begin
                acc_q <= f16;
              end else begin
                thr_q <= sat32(thr_sum);
              end
            end else begin
              unique case (sub)
                SUB_SPRING: spring_q  <= f16;
                SUB_DAMP:   acc_q     <= clamp_acc(acc_diff);
                SUB_DPOS:   pos_q[ax] <= sat32(pos_sum);
                SUB_DVEL:   vel_q[ax] <= sat32(vel_sum);
                default: ;
              endcase
            end
            if (op_q == OP_LAST) begin
              state_q <= ST_OUT;
            end else begin
              op_q    <= op_q + 1'b1;
              state_q <= ST_LOAD;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_ang_q[0] <= in_i.cmd_angle_first;
      cmd_ang_q[1] <= in_i.cmd_angle_second;
      cmd_thr_q    <= in_i.cmd_thrust;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && (!out_valid_q || out_o.ready)) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && (!out_valid_q || out_o.ready)) begin
      out_ang0_q <= pos_q[0];
      out_ang1_q <= pos_q[1];
      out_thr_q  <= thr_q;
    end
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.angle_first  = out_ang0_q;
  assign out_o.angle_second = out_ang1_q;
  assign out_o.thrust_out   = out_thr_q;

  a_load_idle_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> !mul_busy)
    else $error("multiplier started while busy");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == ST_LOAD) && (op_q == '0))
    else $error("accepted beat did not start the sequence");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
    else $error("result raised outside the output state");

  a_op_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_q <= OP_LAST)
    else $error("operation index out of range");

endmodule
